// File: sv/nfsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nfsa_pkg;

  // Default sizing of the allocator.
  localparam int NfsaNumClasses = 16;
  localparam int NfsaMaxSlots   = 64;

  // Request operations.
  typedef enum logic [2:0] {
    OP_OBTAIN      = 3'd0,
    OP_YIELD       = 3'd1,
    OP_SET_SIZE    = 3'd2,
    OP_PREALLOC    = 3'd3,
    OP_RELEASE     = 3'd4,
    OP_RELEASE_ALL = 3'd5
  } op_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_IN_USE  = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  // One request item. The operation is kept raw so that unused codes pass through.
  typedef struct packed {
    logic [2:0] operation;
    logic [3:0] class_index;
    logic [5:0] slot_index;
    logic [6:0] new_size;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0] status;
    logic [5:0] granted_slot;
    logic [6:0] active_size;
  } out_item_t;

endpackage

`default_nettype wire

// File: sv/nfsa_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module nfsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: sv/next_fit_slot_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Next-fit slot allocator for a set of resource classes.
// Requests arrive as items on the input channel (in_valid_i / in_stall_o) and
// every request gives exactly one result item on the output channel
// (out_valid_o / out_stall_i). An item is taken when valid is high and stall
// is low.
// Each request runs in steps: first the class record is read from the class
// memory, then the slot bitmap is searched, the record written back and the
// output register loaded. No new item is taken until the write-back step is
// done; the limit is the single read-modify-write of the class memory per request.
// The result is valid from the cycle after the write-back.
// The input side is taken again while a result waits in the output register;
// when the receiver stalls, the following request holds in its write-back
// step until the output register is free.
// Reset clears the live and size-valid flags of every class, so all classes
// start dead with zero requested size; no clearing pass over the memory is
// needed and the block takes items from the first cycle after reset.
// Release-all clears the live flags in one step.
module next_fit_slot_allocator
  import nfsa_pkg::*;
#(
  parameter int NUM_CLASSES = NfsaNumClasses,
  parameter int MAX_SLOTS   = NfsaMaxSlots
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [7:0] NumClassesW = 8'(NUM_CLASSES);
  localparam logic [6:0] MaxSlotsW   = 7'(MAX_SLOTS);

  // Per-class record held in the class memory.
  typedef struct packed {
    logic [MAX_SLOTS-1:0] taken;
    logic [SW-1:0]        ptr;
    logic [6:0]           active;
    logic [6:0]           req;
  } rec_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e                 state_q, state_d;
  in_item_t               req_q;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_item_q, out_item_d;
  logic [NUM_CLASSES-1:0] live_q, live_d;
  logic [NUM_CLASSES-1:0] szv_q, szv_d;

  logic        accept;
  logic [CW-1:0] caddr;
  logic        in_range;
  logic        cls_live;
  logic        live_n;
  rec_t        rd_rec;
  rec_t        cur;
  rec_t        rec_n;
  logic        ram_we;
  logic        step_done;
  logic [1:0]  status;
  logic [5:0]  granted;

  logic [MAX_SLOTS-1:0] free_vec;
  logic [MAX_SLOTS-1:0] upper_vec;
  logic [SW-1:0]        idx_upper;
  logic [SW-1:0]        idx_any;
  logic [SW-1:0]        idx_sel;
  logic [6:0]           idx_inc;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // The class memory is read with the incoming item's class index.
  nfsa_ram #(
    .WIDTH($bits(rec_t)),
    .DEPTH(NUM_CLASSES)
  ) u_class_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(caddr),
    .wdata_i(rec_n),
    .re_i   (accept),
    .raddr_i(CW'(in_item_i.class_index)),
    .rdata_o(rd_rec)
  );

  // Decode of the held request.
  assign caddr    = CW'(req_q.class_index);
  assign in_range = {4'b0000, req_q.class_index} < NumClassesW;
  assign cls_live = in_range ? live_q[caddr] : 1'b0;

  // A requested size that was never written reads as zero.
  always_comb begin
    cur = rd_rec;
    if (!(in_range && szv_q[caddr])) begin
      cur.req = 7'd0;
    end
  end

  // Free slots within the active size, and those at or above the pointer.
  always_comb begin
    for (int j = 0; j < MAX_SLOTS; j++) begin
      free_vec[j]  = !cur.taken[j] && (7'(j) < cur.active);
      upper_vec[j] = free_vec[j] && (7'(j) >= 7'(cur.ptr));
    end
  end

  // Lowest set bit of each vector.
  always_comb begin
    idx_upper = '0;
    idx_any   = '0;
    for (int j = MAX_SLOTS - 1; j >= 0; j--) begin
      if (upper_vec[j]) begin
        idx_upper = SW'(j);
      end
      if (free_vec[j]) begin
        idx_any = SW'(j);
      end
    end
  end

  assign idx_sel = (|upper_vec) ? idx_upper : idx_any;
  assign idx_inc = 7'(idx_sel) + 7'd1;

  // Request execution: new record, live flag and status.
  always_comb begin
    rec_n   = cur;
    live_n  = cls_live;
    status  = ST_OK;
    granted = 6'd0;
    if (req_q.operation == OP_RELEASE_ALL) begin
      live_n = 1'b0;
    end else if (req_q.operation > OP_RELEASE_ALL || !in_range) begin
      status = ST_INVALID;
    end else begin
      unique case (op_e'(req_q.operation))
        OP_OBTAIN: begin
          if (cur.req == 7'd0) begin
            status = ST_INVALID;
          end else if (!cls_live) begin
            live_n       = 1'b1;
            rec_n.active = cur.req;
            rec_n.taken  = MAX_SLOTS'(1);
            rec_n.ptr    = (cur.req == 7'd1) ? '0 : SW'(1);
          end else if (|free_vec) begin
            rec_n.taken[idx_sel] = 1'b1;
            rec_n.ptr            = (idx_inc == cur.active) ? '0 : SW'(idx_inc);
            granted              = 6'(idx_sel);
          end else begin
            status = ST_IN_USE;
          end
        end
        OP_YIELD: begin
          if (!cls_live || {1'b0, req_q.slot_index} >= cur.active) begin
            status = ST_RANGE;
          end else begin
            rec_n.taken[req_q.slot_index[SW-1:0]] = 1'b0;
            rec_n.ptr = req_q.slot_index[SW-1:0];
          end
        end
        OP_SET_SIZE: begin
          if (req_q.new_size > MaxSlotsW) begin
            status = ST_INVALID;
          end else if (req_q.new_size != cur.req) begin
            if (cls_live) begin
              if (req_q.new_size != 7'd0) begin
                rec_n.active = req_q.new_size;
                rec_n.ptr    = '0;
                rec_n.taken  = '0;
              end else begin
                live_n = 1'b0;
              end
            end
            rec_n.req = req_q.new_size;
          end
        end
        OP_PREALLOC: begin
          if (cur.req != 7'd0) begin
            if (cls_live) begin
              status = ST_INVALID;
            end else begin
              live_n       = 1'b1;
              rec_n.active = cur.req;
              rec_n.ptr    = '0;
              rec_n.taken  = '0;
            end
          end
        end
        OP_RELEASE: begin
          live_n = 1'b0;
        end
        default: begin
          status = ST_INVALID;
        end
      endcase
    end
  end

  // The write-back step completes once the output register can take the result.
  assign step_done = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);
  assign ram_we    = step_done && in_range && (req_q.operation < OP_RELEASE_ALL);

  // Next state of control, flags and output register.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    live_d      = live_q;
    szv_d       = szv_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (step_done) begin
          state_d                 = S_IDLE;
          out_valid_d             = 1'b1;
          out_item_d.status       = status;
          out_item_d.granted_slot = granted;
          out_item_d.active_size  = (in_range && live_n) ? rec_n.active : 7'd0;
          if (req_q.operation == OP_RELEASE_ALL) begin
            live_d = '0;
          end else if (ram_we) begin
            live_d[caddr] = live_n;
            szv_d[caddr]  = 1'b1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, flags and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      live_q      <= '0;
      szv_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
      live_q      <= live_d;
      szv_q       <= szv_d;
    end
  end

  // Request payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_item_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // A new result only ever follows a write-back step.
  a_result_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_EXEC))
    else $error("result appeared without a write-back step");

  // A granted slot lies inside the active size reported with it.
  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_OK && out_item_o.granted_slot != 6'd0)
      |-> ({1'b0, out_item_o.granted_slot} < out_item_o.active_size))
    else $error("granted slot beyond active size");

  // All-in-use is only reported for a live class with slots.
  a_in_use_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.status == ST_IN_USE) |-> (out_item_o.active_size != 7'd0))
    else $error("all-in-use reported for a class without slots");

  // The class memory is written only in the write-back step.
  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_EXEC))
    else $error("class memory written outside the write-back step");

endmodule

`default_nettype wire
